>>> src/bsfw_pkg.sv
package bsfw_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int NUM_KINDS    = 4;

  localparam int RAW_W   = 14;
  localparam int SCALE_W = 16;
  localparam int PROD_W  = RAW_W + SCALE_W;
  localparam int WGT_W   = 16;
  localparam int TEMP_W  = 12;
  localparam int CNT_W   = 32;

  localparam int DIV_STEPS = WGT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 64;

  // reset values of the configuration registers
  localparam logic [RAW_W-1:0]   ZERO_OFFSET_RST = 14'd950;
  localparam logic [SCALE_W-1:0] SCALE_NUM_RST   = 16'd4536;
  localparam logic [SCALE_W-1:0] SCALE_RANGE_RST = 16'd14000;

  // temperature = field * 2000 / 2048 - 500
  localparam logic [10:0]       TEMP_MUL    = 11'd2000;
  localparam logic [TEMP_W-1:0] TEMP_OFFSET = 12'd500;

  localparam logic [WGT_W-1:0] WGT_SAT = '1;

  // register indexes
  localparam logic [1:0] REG_ZERO_OFFSET = 2'd0;
  localparam logic [1:0] REG_SCALE_NUM   = 2'd1;
  localparam logic [1:0] REG_SCALE_RANGE = 2'd2;

  // frame status codes
  localparam logic [1:0] STAT_NORMAL = 2'd0;
  localparam logic [1:0] STAT_STALE  = 2'd2;

  typedef enum logic [1:0] {
    KIND_GOOD  = 2'd0,
    KIND_BUS   = 2'd1,
    KIND_STALE = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_PREP = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

endpackage

>>> src/bridge_sensor_frame_to_weight_unit.sv
// Channel | Port group           | Contents
// --------+----------------------+----------------------------------------------
// in      | in_tvalid/tready     | tdata: channel[1:0], frame[33:2]; tuser: bus_error
// out     | out_tvalid/tready    | tdata: channel, weight, temperature, event_total
//         |                      | tuser: sample_kind
// cfg     | cfg_we/addr/wdata    | 0 zero_offset, 1 scale_numerator, 2 scale_range
//
// A good frame passes through a multiply step, a setup step, 16 steps of a restoring
// divider on a single 17-bit subtractor and the output step before the next accept.
// Bus-error, stale and bad-status items go from accept straight to the output step.
// One item at a time; a result waiting in the output register does not block
// the next accept, but it holds the block in its last step until taken.
// rst_n is synchronous, active low; it clears all per-channel counters and
// reloads the configuration defaults.
module bridge_sensor_frame_to_weight_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bsfw_pkg::IN_DATA_W-1:0]     in_tdata,   // channel[1:0], frame[33:2]
  input  logic                               in_tuser,   // bus_error[0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_channel[1:0], weight[17:2], temperature[29:18], event_total[61:30]
  output logic [bsfw_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [1:0]                         out_tuser,  // sample_kind[1:0]
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_addr,
  input  logic [bsfw_pkg::SCALE_W-1:0]       cfg_wdata
);

  bsfw_pkg::state_t state_r, state_nxt;

  logic [bsfw_pkg::RAW_W-1:0]   zero_offset_r;
  logic [bsfw_pkg::SCALE_W-1:0] scale_num_r;
  logic [bsfw_pkg::SCALE_W-1:0] scale_range_r;

  logic [bsfw_pkg::CNT_W-1:0] cnt_r [bsfw_pkg::NUM_KINDS][bsfw_pkg::NUM_CHANNELS];

  logic [1:0]                     ch_r;
  bsfw_pkg::kind_t                kind_r;
  logic [bsfw_pkg::CNT_W-1:0]     evt_r;
  logic [bsfw_pkg::TEMP_W-1:0]    temp_r;
  logic [bsfw_pkg::RAW_W-1:0]     raw_r;
  logic [bsfw_pkg::PROD_W-1:0]    prod_r;
  logic [bsfw_pkg::SCALE_W-1:0]   rem_r;
  logic [bsfw_pkg::WGT_W-1:0]     quo_r;
  logic                           sat_r;
  logic [bsfw_pkg::DIV_CNT_W-1:0] div_cnt_r;

  logic                           out_tvalid_r;
  logic [bsfw_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic [1:0]                     out_tuser_r;

  // input decode
  logic [1:0]                    in_ch;
  logic                          in_err;
  logic [31:0]                   in_frame;
  logic [bsfw_pkg::RAW_W-1:0]    in_raw;
  logic [10:0]                   in_tfield;
  logic [21:0]                   tprod;
  logic [bsfw_pkg::TEMP_W-1:0]   in_temp;
  bsfw_pkg::kind_t               in_kind;
  logic                          in_ch_ok;
  logic [bsfw_pkg::CH_IDX_W-1:0] in_idx;
  logic [bsfw_pkg::CNT_W-1:0]    evt_nxt;
  logic                          in_acc;
  logic                          out_free;

  // divider step
  logic [bsfw_pkg::SCALE_W:0]    trial;
  logic                          trial_ge;
  logic [bsfw_pkg::SCALE_W:0]    trial_sub;

  assign in_ch     = in_tdata[1:0];
  assign in_frame  = in_tdata[33:2];
  assign in_err    = in_tuser;
  assign in_raw    = in_frame[29:16];
  assign in_tfield = in_frame[15:5];
  assign tprod     = 22'(in_tfield) * 22'(bsfw_pkg::TEMP_MUL);
  assign in_temp   = {1'b0, tprod[21:11]} - bsfw_pkg::TEMP_OFFSET;
  assign in_ch_ok  = 32'(in_ch) < 32'(bsfw_pkg::NUM_CHANNELS);
  assign in_idx    = bsfw_pkg::CH_IDX_W'(in_ch);

  always_comb begin
    if (in_err) begin
      in_kind = bsfw_pkg::KIND_BUS;
    end else begin
      case (in_frame[31:30])
        bsfw_pkg::STAT_NORMAL: in_kind = bsfw_pkg::KIND_GOOD;
        bsfw_pkg::STAT_STALE:  in_kind = bsfw_pkg::KIND_STALE;
        default:               in_kind = bsfw_pkg::KIND_BAD;
      endcase
    end
  end

  assign evt_nxt   = in_ch_ok ? cnt_r[in_kind][in_idx] + 32'd1 : '0;
  assign in_tready = (state_r == bsfw_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // restoring divide: shift in next dividend bit, subtract range when it fits
  assign trial     = {rem_r, quo_r[bsfw_pkg::WGT_W-1]};
  assign trial_ge  = trial >= {1'b0, scale_range_r};
  assign trial_sub = trial - {1'b0, scale_range_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsfw_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_kind == bsfw_pkg::KIND_GOOD) ? bsfw_pkg::S_MUL : bsfw_pkg::S_OUT;
        end
      end
      bsfw_pkg::S_MUL:  state_nxt = bsfw_pkg::S_PREP;
      bsfw_pkg::S_PREP: state_nxt = bsfw_pkg::S_DIV;
      bsfw_pkg::S_DIV: begin
        if (div_cnt_r == bsfw_pkg::DIV_CNT_W'(bsfw_pkg::DIV_STEPS - 1)) begin
          state_nxt = bsfw_pkg::S_OUT;
        end
      end
      bsfw_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = bsfw_pkg::S_IDLE;
        end
      end
      default: state_nxt = bsfw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bsfw_pkg::S_IDLE;
      out_tvalid_r  <= 1'b0;
      zero_offset_r <= bsfw_pkg::ZERO_OFFSET_RST;
      scale_num_r   <= bsfw_pkg::SCALE_NUM_RST;
      scale_range_r <= bsfw_pkg::SCALE_RANGE_RST;
      for (int k = 0; k < bsfw_pkg::NUM_KINDS; k++) begin
        for (int c = 0; c < bsfw_pkg::NUM_CHANNELS; c++) begin
          cnt_r[k][c] <= '0;
        end
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          bsfw_pkg::REG_ZERO_OFFSET: zero_offset_r <= cfg_wdata[bsfw_pkg::RAW_W-1:0];
          bsfw_pkg::REG_SCALE_NUM:   scale_num_r   <= cfg_wdata;
          bsfw_pkg::REG_SCALE_RANGE: scale_range_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc && in_ch_ok) begin
        cnt_r[in_kind][in_idx] <= evt_nxt;
      end
      if (state_r == bsfw_pkg::S_OUT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state_r)
      bsfw_pkg::S_IDLE: begin
        if (in_acc) begin
          ch_r   <= in_ch;
          kind_r <= in_kind;
          evt_r  <= evt_nxt;
          temp_r <= in_temp;
          raw_r  <= (in_raw < zero_offset_r) ? '0 : in_raw - zero_offset_r;
          quo_r  <= '0;
          sat_r  <= 1'b0;
        end
      end
      bsfw_pkg::S_MUL: begin
        prod_r <= bsfw_pkg::PROD_W'(raw_r) * bsfw_pkg::PROD_W'(scale_num_r);
      end
      bsfw_pkg::S_PREP: begin
        // quotient exceeds 16 bits iff the upper part alone reaches the range
        sat_r     <= {2'b00, prod_r[bsfw_pkg::PROD_W-1:bsfw_pkg::WGT_W]} >= scale_range_r;
        rem_r     <= {2'b00, prod_r[bsfw_pkg::PROD_W-1:bsfw_pkg::WGT_W]};
        quo_r     <= prod_r[bsfw_pkg::WGT_W-1:0];
        div_cnt_r <= '0;
      end
      bsfw_pkg::S_DIV: begin
        rem_r     <= trial_ge ? trial_sub[bsfw_pkg::SCALE_W-1:0]
                              : trial[bsfw_pkg::SCALE_W-1:0];
        quo_r     <= {quo_r[bsfw_pkg::WGT_W-2:0], trial_ge};
        div_cnt_r <= div_cnt_r + bsfw_pkg::DIV_CNT_W'(1);
      end
      bsfw_pkg::S_OUT: begin
        if (out_free) begin
          out_tuser_r <= kind_r;
          if (kind_r == bsfw_pkg::KIND_GOOD) begin
            out_tdata_r <= {2'b00, evt_r, temp_r, (sat_r ? bsfw_pkg::WGT_SAT : quo_r), ch_r};
          end else begin
            out_tdata_r <= {2'b00, evt_r, bsfw_pkg::TEMP_W'(0), bsfw_pkg::WGT_W'(0), ch_r};
          end
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_rise_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == bsfw_pkg::S_OUT))
    else $error("result raised outside the output step");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != bsfw_pkg::S_IDLE)
    else $error("accepted item did not start work");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bsfw_pkg::S_DIV &&
     div_cnt_r == bsfw_pkg::DIV_CNT_W'(bsfw_pkg::DIV_STEPS - 1)) |=> state_r == bsfw_pkg::S_OUT)
    else $error("divider did not finish after its last step");

  a_zero_unless_good: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r != bsfw_pkg::KIND_GOOD) |-> out_tdata_r[29:2] == '0)
    else $error("weight or temperature set on a non-good item");

  a_rem_below_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bsfw_pkg::S_DIV && !sat_r) |-> rem_r < scale_range_r)
    else $error("divider remainder out of range");

endmodule

>>> test/tb_bridge_sensor_frame_to_weight_unit.sv
module tb_bridge_sensor_frame_to_weight_unit;

  localparam logic [1:0] REG_UNUSED = 2'd3;   // past the register list, must be ignored
  localparam logic [1:0] STAT_BAD_A = 2'd1;
  localparam logic [1:0] STAT_BAD_B = 2'd3;
  localparam int PLAN_ROWS = 27;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [1:0]       ch;
    bsfw_pkg::kind_t  kind;
    logic [15:0]      weight;
    logic [11:0]      temp;
    logic [31:0]      total;
  } reading_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;

  // sel is the channel for an item row, the register index for a cfg row
  typedef struct packed {
    row_op_t     op;
    logic [1:0]  sel;
    logic        err;
    logic [31:0] value;
    logic        typed;
    reading_t    res;
  } plan_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [bsfw_pkg::IN_DATA_W-1:0]  in_tdata = '0;   // channel[1:0], frame[33:2]
  logic                            in_tuser = 1'b0; // bus_error[0]
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // out_channel[1:0], weight[17:2], temperature[29:18], event_total[61:30]
  logic [bsfw_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0]                      out_tuser;       // sample_kind[1:0]
  logic                            cfg_we = 1'b0;
  logic [1:0]                      cfg_addr = '0;
  logic [bsfw_pkg::SCALE_W-1:0]    cfg_wdata = '0;

  // predictor state
  logic [bsfw_pkg::RAW_W-1:0]   cal_offset = bsfw_pkg::ZERO_OFFSET_RST;
  logic [bsfw_pkg::SCALE_W-1:0] cal_num    = bsfw_pkg::SCALE_NUM_RST;
  logic [bsfw_pkg::SCALE_W-1:0] cal_range  = bsfw_pkg::SCALE_RANGE_RST;
  logic [31:0] kind_tally [bsfw_pkg::NUM_KINDS][bsfw_pkg::NUM_CHANNELS] = '{default: '0};

  reading_t  pending_readings [$];
  plan_row_t plan [PLAN_ROWS];
  int        errors = 0;
  int        idle_odds = 0;   // 0: no idling, else one chance in idle_odds per item/cycle
  bit        calm = 1'b0;
  int        stall_left = 0;

  bridge_sensor_frame_to_weight_unit DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("ERROR %s: expected %0h, got %0h", what, want, got);
    errors++;
  endtask

  function automatic reading_t weigh_frame(input logic [1:0] ch, input logic err,
                                           input logic [31:0] frame);
    reading_t    r;
    logic [13:0] raw;
    logic [63:0] w;
    logic [31:0] tq;
    r = '0;
    r.ch = ch;
    if (err) r.kind = bsfw_pkg::KIND_BUS;
    else if (frame[31:30] == bsfw_pkg::STAT_NORMAL) r.kind = bsfw_pkg::KIND_GOOD;
    else if (frame[31:30] == bsfw_pkg::STAT_STALE) r.kind = bsfw_pkg::KIND_STALE;
    else r.kind = bsfw_pkg::KIND_BAD;
    if (r.kind == bsfw_pkg::KIND_GOOD) begin
      raw = frame[29:16];
      raw = (raw < cal_offset) ? 14'd0 : raw - cal_offset;
      if (cal_range == '0) begin
        r.weight = 16'hFFFF;
      end else begin
        w = (64'(raw) * 64'(cal_num)) / 64'(cal_range);
        r.weight = (w > 64'd65535) ? 16'hFFFF : w[15:0];
      end
      tq = ({21'd0, frame[15:5]} * 32'd2000) / 32'd2048;
      r.temp = tq[11:0] - 12'd500;
    end
    if (int'(ch) < bsfw_pkg::NUM_CHANNELS) begin
      kind_tally[r.kind][ch] = kind_tally[r.kind][ch] + 32'd1;
      r.total = kind_tally[r.kind][ch];
    end
    return r;
  endfunction

  task automatic feed(input logic [1:0] ch, input logic err, input logic [31:0] frame,
                      input logic typed, input reading_t typed_res);
    reading_t r;
    if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, frame, ch};
    in_tuser  <= err;
    do @(posedge clk); while (in_tready !== 1'b1);
    r = weigh_frame(ch, err, frame);
    pending_readings.push_back(typed ? typed_res : r);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] addr, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (addr)
      bsfw_pkg::REG_ZERO_OFFSET: cal_offset = data[13:0];
      bsfw_pkg::REG_SCALE_NUM:   cal_num = data;
      bsfw_pkg::REG_SCALE_RANGE: cal_range = data;
      default: ;
    endcase
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("result with nothing pending", '0, out_tdata[31:0]);
      end else begin
        want = pending_readings.pop_front();
        if (out_tdata[1:0] !== want.ch)
          report_mismatch("channel", want.ch, out_tdata[1:0]);
        if (out_tuser !== want.kind)
          report_mismatch("sample kind", want.kind, out_tuser);
        if (out_tdata[17:2] !== want.weight)
          report_mismatch("weight", want.weight, out_tdata[17:2]);
        if (out_tdata[29:18] !== want.temp)
          report_mismatch("temperature", want.temp, out_tdata[29:18]);
        if (out_tdata[61:30] !== want.total)
          report_mismatch("event total", want.total, out_tdata[61:30]);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int          ph;
    int          n;
    int          pick;
    logic [1:0]  ch;
    logic        err;
    logic [31:0] frame;
    logic        prev_item;

    plan = '{
      // defaults after reset
      '{ROW_ITEM, 2'd0, 1'b1, 32'hFFFF_FFFF, 1'b1,
        '{2'd0, bsfw_pkg::KIND_BUS, 16'd0, 12'd0, 32'd1}},
      '{ROW_ITEM, 2'd0, 1'b0, 32'h0000_0000, 1'b1,
        '{2'd0, bsfw_pkg::KIND_GOOD, 16'd0, -12'd500, 32'd1}},
      '{ROW_ITEM, 2'd0, 1'b0, 32'h3FFF_FFFF, 1'b1,
        '{2'd0, bsfw_pkg::KIND_GOOD, 16'd5000, 12'd1499, 32'd2}},
      '{ROW_ITEM, 2'd3, 1'b0, 32'h8000_0000, 1'b1,
        '{2'd3, bsfw_pkg::KIND_STALE, 16'd0, 12'd0, 32'd1}},
      '{ROW_ITEM, 2'd2, 1'b0, 32'h4000_0000, 1'b1,
        '{2'd2, bsfw_pkg::KIND_BAD, 16'd0, 12'd0, 32'd1}},
      '{ROW_ITEM, 2'd1, 1'b0, 32'hC000_1234, 1'b1,
        '{2'd1, bsfw_pkg::KIND_BAD, 16'd0, 12'd0, 32'd1}},
      '{ROW_ITEM, 2'd1, 1'b1, 32'h0000_0000, 1'b1,
        '{2'd1, bsfw_pkg::KIND_BUS, 16'd0, 12'd0, 32'd1}},
      // bridge count equal to the offset
      '{ROW_ITEM, 2'd3, 1'b0, 32'h03B6_0000, 1'b1,
        '{2'd3, bsfw_pkg::KIND_GOOD, 16'd0, -12'd500, 32'd1}},
      '{ROW_ITEM, 2'd3, 1'b0, 32'h03B7_0000, 1'b0, '0},
      '{ROW_ITEM, 2'd2, 1'b0, 32'h2AAA_5555, 1'b0, '0},
      '{ROW_ITEM, 2'd2, 1'b0, 32'h1555_AAAA, 1'b0, '0},
      '{ROW_ITEM, 2'd0, 1'b0, 32'hBFFF_FFFF, 1'b1,
        '{2'd0, bsfw_pkg::KIND_STALE, 16'd0, 12'd0, 32'd1}},
      '{ROW_ITEM, 2'd1, 1'b0, 32'h0000_8000, 1'b1,
        '{2'd1, bsfw_pkg::KIND_GOOD, 16'd0, 12'd500, 32'd1}},
      '{ROW_ITEM, 2'd2, 1'b1, 32'h8000_0000, 1'b1,
        '{2'd2, bsfw_pkg::KIND_BUS, 16'd0, 12'd0, 32'd1}},
      // no offset, full gain, unit range: saturation
      '{ROW_CFG, bsfw_pkg::REG_ZERO_OFFSET, 1'b0, 32'h0000, 1'b0, '0},
      '{ROW_CFG, bsfw_pkg::REG_SCALE_NUM, 1'b0, 32'hFFFF, 1'b0, '0},
      '{ROW_CFG, bsfw_pkg::REG_SCALE_RANGE, 1'b0, 32'h0001, 1'b0, '0},
      '{ROW_CFG, REG_UNUSED, 1'b0, 32'h1234, 1'b0, '0},
      '{ROW_ITEM, 2'd0, 1'b0, 32'h3FFF_0000, 1'b1,
        '{2'd0, bsfw_pkg::KIND_GOOD, 16'hFFFF, -12'd500, 32'd3}},
      '{ROW_ITEM, 2'd1, 1'b0, 32'h0001_0000, 1'b0, '0},
      // zero range saturates even on a zero count
      '{ROW_CFG, bsfw_pkg::REG_SCALE_RANGE, 1'b0, 32'h0000, 1'b0, '0},
      '{ROW_ITEM, 2'd2, 1'b0, 32'h0000_0000, 1'b1,
        '{2'd2, bsfw_pkg::KIND_GOOD, 16'hFFFF, -12'd500, 32'd3}},
      // offset written with spare upper bits
      '{ROW_CFG, bsfw_pkg::REG_ZERO_OFFSET, 1'b0, 32'hFFFF, 1'b0, '0},
      '{ROW_CFG, bsfw_pkg::REG_SCALE_RANGE, 1'b0, 32'hFFFF, 1'b0, '0},
      '{ROW_ITEM, 2'd3, 1'b0, 32'h3FFF_FFE0, 1'b0, '0},
      '{ROW_CFG, bsfw_pkg::REG_SCALE_NUM, 1'b0, 32'h0000, 1'b0, '0},
      '{ROW_ITEM, 2'd3, 1'b0, 32'h3FFF_7FFF, 1'b0, '0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_item = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].op == ROW_CFG) begin
        if (prev_item) drain();
        set_reg(plan[i].sel, plan[i].value[15:0]);
        prev_item = 1'b0;
      end else begin
        feed(plan[i].sel, plan[i].err, plan[i].value, plan[i].typed, plan[i].res);
        prev_item = 1'b1;
      end
    end

    for (ph = 0; ph < 7; ph++) begin
      drain();
      if (ph == 0) begin
        set_reg(bsfw_pkg::REG_ZERO_OFFSET, 16'(bsfw_pkg::ZERO_OFFSET_RST));
        set_reg(bsfw_pkg::REG_SCALE_NUM, bsfw_pkg::SCALE_NUM_RST);
        set_reg(bsfw_pkg::REG_SCALE_RANGE, bsfw_pkg::SCALE_RANGE_RST);
      end else begin
        case ($urandom_range(0, 3))
          0: set_reg(bsfw_pkg::REG_ZERO_OFFSET, 16'h0000);
          1: set_reg(bsfw_pkg::REG_ZERO_OFFSET, 16'hFFFF);
          default: set_reg(bsfw_pkg::REG_ZERO_OFFSET, 16'($urandom));
        endcase
        case ($urandom_range(0, 3))
          0: set_reg(bsfw_pkg::REG_SCALE_NUM, 16'h0000);
          1: set_reg(bsfw_pkg::REG_SCALE_NUM, 16'hFFFF);
          default: set_reg(bsfw_pkg::REG_SCALE_NUM, 16'($urandom));
        endcase
        case ($urandom_range(0, 4))
          0: set_reg(bsfw_pkg::REG_SCALE_RANGE, 16'h0000);
          1: set_reg(bsfw_pkg::REG_SCALE_RANGE, 16'h0001);
          2: set_reg(bsfw_pkg::REG_SCALE_RANGE, 16'hFFFF);
          default: set_reg(bsfw_pkg::REG_SCALE_RANGE, 16'($urandom));
        endcase
        if ($urandom_range(0, 2) == 0) set_reg(REG_UNUSED, 16'($urandom));
      end
      idle_odds = (ph % 3 == 2) ? 0 : $urandom_range(2, 8);

      for (n = 0; n < 250; n++) begin
        if (ph == 6 && n >= 100) calm = 1'b1;
        ch = 2'($urandom_range(0, 3));
        frame = $urandom;
        err = 1'b0;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          err = 1'b1;
        end else if (pick == 1) begin
          frame[31:30] = bsfw_pkg::STAT_STALE;
        end else if (pick == 2) begin
          frame[31:30] = $urandom_range(0, 1) ? STAT_BAD_A : STAT_BAD_B;
        end else begin
          frame[31:30] = bsfw_pkg::STAT_NORMAL;
          case ($urandom_range(0, 3))
            // around the offset, where the clamp kicks in
            0: frame[29:16] = 14'(cal_offset + $urandom_range(0, 40) - 20);
            1: frame[29:16] = $urandom_range(0, 1) ? 14'h3FFF : 14'h0000;
            default: ;
          endcase
        end
        feed(ch, err, frame, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
src/bsfw_pkg.sv
src/bridge_sensor_frame_to_weight_unit.sv
test/tb_bridge_sensor_frame_to_weight_unit.sv
